@@ rtl/core/dcap_pkg.sv @@
// Shared types and constants for the dual-channel average packetizer.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package dcap_pkg;

    // Field widths fixed by the interface.
    localparam int SAMPLE_W  = 12;
    localparam int SUM_W     = 24;
    localparam int WORD_W    = 32;
    localparam int SLOT_W    = 4;
    localparam int POS_W     = 2;

    // Header register value after reset.
    localparam logic [WORD_W-1:0] HEADER_RESET = 32'h0000_AA55;

    // Position codes of the four words of a packet.
    localparam logic [POS_W-1:0] POS_HEADER  = 2'd0;
    localparam logic [POS_W-1:0] POS_COUNTER = 2'd1;
    localparam logic [POS_W-1:0] POS_MASTER  = 2'd2;
    localparam logic [POS_W-1:0] POS_SLAVE   = 2'd3;

    // A finished window, waiting to be framed: raw sums plus framing data.
    typedef struct packed {
        logic [WORD_W-1:0] header;
        logic [WORD_W-1:0] counter;
        logic [SUM_W-1:0]  master_sum;
        logic [SUM_W-1:0]  slave_sum;
        logic [SLOT_W-1:0] slot;
        logic              half;
        logic              done;
    } t_window;

    // Hand-off from the accumulator to the serializer.
    typedef struct packed {
        logic    valid;
        t_window win;
    } t_pending;

endpackage

@@ rtl/core/dual_channel_average_packetizer.sv @@
// Top level of the dual-channel average packetizer.
// Depends on dcap_pkg, dcap_accum and dcap_serial.
`timescale 1ns / 1ps

// Usage:
// The input channel (i_valid / o_ready) carries one master and one slave
// 12-bit sample per transaction. Every HALF_WINDOW transactions the block
// frames one packet of four 32-bit words on the output channel
// (o_valid / i_ready): header, packet counter, master average, slave
// average, each tagged with its position, slot, buffer half and last flag.
// The user must write the header register through i_cfg_wr_en /
// i_cfg_wr_data only while the block is idle; the block does not enforce it.
// A closed window passes through the pending register into the serializer,
// which offers the header word first and the rest one per ready cycle.
// Throughput: one sample pair per cycle when HALF_WINDOW is four or more
// and the receiver does not stall; shorter windows are limited by the word
// serializer, which sends the four words of each packet one by one.
// A stalled receiver holds the current word. Sampling continues while the
// serializer holds one packet and the pending register the next; the
// transaction that closes a further window then waits with o_ready low.
// Reset clears the sums, the counters, the slot and buffer half, and loads
// the header register with 0x0000AA55.
module dual_channel_average_packetizer #(
    parameter int HALF_WINDOW        = 32,
    parameter int PACKETS_PER_BUFFER = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [dcap_pkg::WORD_W-1:0]   i_cfg_wr_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [dcap_pkg::SAMPLE_W-1:0] i_master_sample,
    input  logic [dcap_pkg::SAMPLE_W-1:0] i_slave_sample,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [dcap_pkg::WORD_W-1:0]   o_packet_word,
    output logic [dcap_pkg::POS_W-1:0]    o_word_position,
    output logic [dcap_pkg::SLOT_W-1:0]   o_packet_slot,
    output logic                          o_buffer_half,
    output logic                          o_buffer_complete,
    output logic                          o_last
);

    logic [dcap_pkg::WORD_W-1:0] r_header;
    dcap_pkg::t_pending          pending;
    logic                        take;

    // Header configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header <= dcap_pkg::HEADER_RESET;
        end else if (i_cfg_wr_en) begin
            r_header <= i_cfg_wr_data;
        end
    end

    // Sample sums and window framing.
    dcap_accum #(
        .HALF_WINDOW        (HALF_WINDOW),
        .PACKETS_PER_BUFFER (PACKETS_PER_BUFFER)
    ) u_accum (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_master_sample (i_master_sample),
        .i_slave_sample  (i_slave_sample),
        .i_header        (r_header),
        .i_take          (take),
        .o_pending       (pending)
    );

    // Averages and word output.
    dcap_serial #(
        .HALF_WINDOW (HALF_WINDOW)
    ) u_serial (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_pending         (pending),
        .o_take            (take),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_packet_word     (o_packet_word),
        .o_word_position   (o_word_position),
        .o_packet_slot     (o_packet_slot),
        .o_buffer_half     (o_buffer_half),
        .o_buffer_complete (o_buffer_complete),
        .o_last            (o_last)
    );

endmodule

@@ rtl/core/dcap_accum.sv @@
// Sample accumulator: running sums, window count and packet framing state.
// Depends on dcap_pkg; feeds one pending window to dcap_serial.
`timescale 1ns / 1ps

module dcap_accum #(
    parameter int HALF_WINDOW        = 32,
    parameter int PACKETS_PER_BUFFER = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [dcap_pkg::SAMPLE_W-1:0]  i_master_sample,
    input  logic [dcap_pkg::SAMPLE_W-1:0]  i_slave_sample,
    input  logic [dcap_pkg::WORD_W-1:0]    i_header,
    input  logic                           i_take,
    output dcap_pkg::t_pending             o_pending
);

    localparam int CNT_W = (HALF_WINDOW > 1) ? $clog2(HALF_WINDOW) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HALF_WINDOW - 1);
    localparam logic [dcap_pkg::SLOT_W-1:0] SLOT_LAST =
        dcap_pkg::SLOT_W'(PACKETS_PER_BUFFER - 1);

    logic [dcap_pkg::SUM_W-1:0]  r_master_sum, n_master_sum;
    logic [dcap_pkg::SUM_W-1:0]  r_slave_sum,  n_slave_sum;
    logic [CNT_W-1:0]            r_count,      n_count;
    logic [dcap_pkg::WORD_W-1:0] r_counter,    n_counter;
    logic [dcap_pkg::SLOT_W-1:0] r_slot,       n_slot;
    logic                        r_half,       n_half;
    logic                        r_pend_valid, n_pend_valid;
    dcap_pkg::t_window           r_win,        n_win;

    logic                        window_end;
    logic                        accept;
    logic                        capture;
    logic                        slot_wrap;
    logic [dcap_pkg::SUM_W-1:0]  master_add;
    logic [dcap_pkg::SUM_W-1:0]  slave_add;

    // The closing sample of a window needs the pending register free.
    assign window_end = (r_count == CNT_LAST);
    assign o_ready    = !(r_pend_valid && window_end);
    assign accept     = i_valid && o_ready;
    assign capture    = accept && window_end;
    assign slot_wrap  = (r_slot == SLOT_LAST);

    // Running sums including the sample of this transaction.
    assign master_add = r_master_sum + dcap_pkg::SUM_W'(i_master_sample);
    assign slave_add  = r_slave_sum  + dcap_pkg::SUM_W'(i_slave_sample);

    // Next state of the accumulator and the framing counters.
    always_comb begin
        n_master_sum = r_master_sum;
        n_slave_sum  = r_slave_sum;
        n_count      = r_count;
        n_counter    = r_counter;
        n_slot       = r_slot;
        n_half       = r_half;
        n_win        = r_win;
        n_pend_valid = r_pend_valid;
        if (i_take) begin
            n_pend_valid = 1'b0;
        end
        if (capture) begin
            n_master_sum     = '0;
            n_slave_sum      = '0;
            n_count          = '0;
            n_counter        = r_counter + 1'b1;
            n_win.header     = i_header;
            n_win.counter    = r_counter;
            n_win.master_sum = master_add;
            n_win.slave_sum  = slave_add;
            n_win.slot       = r_slot;
            n_win.half       = r_half;
            n_win.done       = slot_wrap;
            n_pend_valid     = 1'b1;
            if (slot_wrap) begin
                n_slot = '0;
                n_half = !r_half;
            end else begin
                n_slot = r_slot + 1'b1;
            end
        end else if (accept) begin
            n_master_sum = master_add;
            n_slave_sum  = slave_add;
            n_count      = r_count + 1'b1;
        end
    end

    // Control state under reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_master_sum <= '0;
            r_slave_sum  <= '0;
            r_count      <= '0;
            r_counter    <= '0;
            r_slot       <= '0;
            r_half       <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_master_sum <= n_master_sum;
            r_slave_sum  <= n_slave_sum;
            r_count      <= n_count;
            r_counter    <= n_counter;
            r_slot       <= n_slot;
            r_half       <= n_half;
            r_pend_valid <= n_pend_valid;
        end
    end

    // Pending window payload.
    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

    assign o_pending.valid = r_pend_valid;
    assign o_pending.win   = r_win;

endmodule

@@ rtl/core/dcap_serial.sv @@
// Packet serializer: divides the window sums and sends four words per packet.
// Depends on dcap_pkg; takes windows from dcap_accum.
`timescale 1ns / 1ps

module dcap_serial #(
    parameter int HALF_WINDOW = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dcap_pkg::t_pending            i_pending,
    output logic                          o_take,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [dcap_pkg::WORD_W-1:0]   o_packet_word,
    output logic [dcap_pkg::POS_W-1:0]    o_word_position,
    output logic [dcap_pkg::SLOT_W-1:0]   o_packet_slot,
    output logic                          o_buffer_half,
    output logic                          o_buffer_complete,
    output logic                          o_last
);

    // Floor division by a constant: multiply by a rounded-up reciprocal.
    // With l = ceil(log2(d)) and shift N + l the quotient is exact for
    // every N-bit dividend, and the reciprocal fits in N + 1 bits.
    localparam int SHIFT   = dcap_pkg::SUM_W + $clog2(HALF_WINDOW);
    localparam int RECIP_W = dcap_pkg::SUM_W + 1;
    localparam int PROD_W  = dcap_pkg::SUM_W + RECIP_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(HALF_WINDOW) - 64'd1) / 64'(HALF_WINDOW);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

    logic                         r_busy, n_busy;
    logic [dcap_pkg::POS_W-1:0]   r_pos,  n_pos;
    logic [dcap_pkg::WORD_W-1:0]  r_header,  n_header;
    logic [dcap_pkg::WORD_W-1:0]  r_counter, n_counter;
    logic [dcap_pkg::SUM_W-1:0]   r_master_avg, n_master_avg;
    logic [dcap_pkg::SUM_W-1:0]   r_slave_avg,  n_slave_avg;
    logic [dcap_pkg::SLOT_W-1:0]  r_slot, n_slot;
    logic                         r_half, n_half;
    logic                         r_done, n_done;

    logic [PROD_W-1:0]            master_prod;
    logic [PROD_W-1:0]            slave_prod;
    logic                         out_fire;
    logic                         pos_last;

    assign pos_last = (r_pos == dcap_pkg::POS_SLAVE);
    assign out_fire = r_busy && i_ready;

    // A new window loads when idle or as the final word leaves.
    assign o_take = i_pending.valid && (!r_busy || (out_fire && pos_last));

    assign master_prod = PROD_W'(i_pending.win.master_sum) * PROD_W'(RECIP);
    assign slave_prod  = PROD_W'(i_pending.win.slave_sum)  * PROD_W'(RECIP);

    // Word sequencing and packet load.
    always_comb begin
        n_busy       = r_busy;
        n_pos        = r_pos;
        n_header     = r_header;
        n_counter    = r_counter;
        n_master_avg = r_master_avg;
        n_slave_avg  = r_slave_avg;
        n_slot       = r_slot;
        n_half       = r_half;
        n_done       = r_done;
        if (out_fire) begin
            if (pos_last) begin
                n_busy = 1'b0;
            end else begin
                n_pos = r_pos + 1'b1;
            end
        end
        if (o_take) begin
            n_busy       = 1'b1;
            n_pos        = dcap_pkg::POS_HEADER;
            n_header     = i_pending.win.header;
            n_counter    = i_pending.win.counter;
            n_master_avg = dcap_pkg::SUM_W'(master_prod >> SHIFT);
            n_slave_avg  = dcap_pkg::SUM_W'(slave_prod  >> SHIFT);
            n_slot       = i_pending.win.slot;
            n_half       = i_pending.win.half;
            n_done       = i_pending.win.done;
        end
    end

    // Control state under reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= dcap_pkg::POS_HEADER;
        end else begin
            r_busy <= n_busy;
            r_pos  <= n_pos;
        end
    end

    // Packet payload.
    always_ff @(posedge i_clk) begin
        r_header     <= n_header;
        r_counter    <= n_counter;
        r_master_avg <= n_master_avg;
        r_slave_avg  <= n_slave_avg;
        r_slot       <= n_slot;
        r_half       <= n_half;
        r_done       <= n_done;
    end

    // Select the word for the current position.
    always_comb begin
        case (r_pos)
            dcap_pkg::POS_HEADER:  o_packet_word = r_header;
            dcap_pkg::POS_COUNTER: o_packet_word = r_counter;
            dcap_pkg::POS_MASTER:  o_packet_word = dcap_pkg::WORD_W'(r_master_avg);
            dcap_pkg::POS_SLAVE:   o_packet_word = dcap_pkg::WORD_W'(r_slave_avg);
            default:               o_packet_word = r_header;
        endcase
    end

    assign o_valid           = r_busy;
    assign o_word_position   = r_pos;
    assign o_packet_slot     = r_slot;
    assign o_buffer_half     = r_half;
    assign o_last            = pos_last;
    assign o_buffer_complete = pos_last && r_done;

endmodule

@@ rtl/core/dcap_checker.sv @@
// Port-level checker for the dual-channel average packetizer.
// Depends on dcap_pkg; bound to dual_channel_average_packetizer below.
`timescale 1ns / 1ps

module dcap_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [dcap_pkg::WORD_W-1:0]   o_packet_word,
    input logic [dcap_pkg::POS_W-1:0]    o_word_position,
    input logic                          o_buffer_complete,
    input logic                          o_last
);

    // No output transaction is offered right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // A stalled word holds its value.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_packet_word)
            && $stable(o_word_position))
        else $error("stalled output word changed");

    // Words of a packet follow in order without a gap.
    a_word_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=>
            o_valid && (o_word_position == $past(o_word_position) + 2'd1))
        else $error("packet word out of order");

    // The last flag marks exactly the slave average word.
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_word_position == dcap_pkg::POS_SLAVE)))
        else $error("last flag on wrong word");

    // Buffer completion only on a packet's last word.
    a_complete_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_buffer_complete |-> o_last)
        else $error("buffer complete without last");

endmodule

bind dual_channel_average_packetizer dcap_checker u_dcap_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_packet_word     (o_packet_word),
    .o_word_position   (o_word_position),
    .o_buffer_complete (o_buffer_complete),
    .o_last            (o_last)
);

@@ sim/tb_top.sv @@
// Self-checking testbench for the dual-channel average packetizer.
// Depends on dcap_pkg and dual_channel_average_packetizer; it predicts every
// packet word in step with the accepted sample pairs and checks each one in order.
`timescale 1ns / 1ps

module tb_top;

    localparam int HALF_WINDOW        = 32;
    localparam int PACKETS_PER_BUFFER = 16;
    localparam int RANDOM_ITEMS       = 64;
    localparam int CFG_SETTLE         = 8;
    localparam int END_SETTLE         = 24;
    localparam int HOLD_OFF_CYCLES    = 400;
    localparam int REPORT_LIMIT       = 10;
    localparam int unsigned CYCLE_LIMIT = 200000;

    // How the samples of one window are drawn.
    typedef enum int {
        FLAVOR_UNIFORM,
        FLAVOR_FULL_SCALE,
        FLAVOR_ZERO,
        FLAVOR_CORNERS,
        FLAVOR_SPLIT
    } t_window_flavor;

    // How the receiver paces the output channel.
    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN
    } t_rx_mode;

    // One predicted word of a packet with its framing tags.
    typedef struct packed {
        logic [dcap_pkg::WORD_W-1:0] word;
        logic [dcap_pkg::POS_W-1:0]  pos;
        logic [dcap_pkg::SLOT_W-1:0] slot;
        logic                        half;
        logic                        buf_done;
        logic                        last;
    } t_framed_word;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_wr_en;
    logic [dcap_pkg::WORD_W-1:0]   i_cfg_wr_data;
    logic                          i_valid;
    logic                          o_ready;
    logic [dcap_pkg::SAMPLE_W-1:0] i_master_sample;
    logic [dcap_pkg::SAMPLE_W-1:0] i_slave_sample;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic [dcap_pkg::WORD_W-1:0]   o_packet_word;
    logic [dcap_pkg::POS_W-1:0]    o_word_position;
    logic [dcap_pkg::SLOT_W-1:0]   o_packet_slot;
    logic                          o_buffer_half;
    logic                          o_buffer_complete;
    logic                          o_last;

    // Predictor state: header register, running sums and framing counters.
    logic [dcap_pkg::WORD_W-1:0] header_model;
    logic [dcap_pkg::SUM_W-1:0]  master_acc;
    logic [dcap_pkg::SUM_W-1:0]  slave_acc;
    int unsigned                 fill_count;
    logic [dcap_pkg::WORD_W-1:0] packet_count;
    logic [dcap_pkg::SLOT_W-1:0] slot_model;
    logic                        half_model;

    t_framed_word expected_words[$];
    int unsigned  mismatch_count = 0;
    int unsigned  cycle_count = 0;
    logic         valid_high = 1'b0;
    t_rx_mode     rx_mode = RX_ALWAYS;
    logic         rx_hold = 1'b0;
    logic [15:0]  rx_pattern = 16'b1011_0011_1000_1101;

    dual_channel_average_packetizer #(
        .HALF_WINDOW        (HALF_WINDOW),
        .PACKETS_PER_BUFFER (PACKETS_PER_BUFFER)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_master_sample   (i_master_sample),
        .i_slave_sample    (i_slave_sample),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_packet_word     (o_packet_word),
        .o_word_position   (o_word_position),
        .o_packet_slot     (o_packet_slot),
        .o_buffer_half     (o_buffer_half),
        .o_buffer_complete (o_buffer_complete),
        .o_last            (o_last)
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("dual_channel_average_packetizer: mismatch");
            $finish;
        end
    end

    function automatic void record_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
            $display("%s", msg);
        end
    endfunction

    function automatic void reset_model();
        header_model = dcap_pkg::HEADER_RESET;
        master_acc   = '0;
        slave_acc    = '0;
        fill_count   = 0;
        packet_count = '0;
        slot_model   = '0;
        half_model   = 1'b0;
    endfunction

    function automatic void push_word(input logic [dcap_pkg::WORD_W-1:0] word,
                                      input logic [dcap_pkg::POS_W-1:0] pos,
                                      input logic closes_buffer);
        t_framed_word w;
        w.word     = word;
        w.pos      = pos;
        w.slot     = slot_model;
        w.half     = half_model;
        w.last     = (pos == dcap_pkg::POS_SLAVE);
        w.buf_done = closes_buffer && (pos == dcap_pkg::POS_SLAVE);
        expected_words.push_back(w);
    endfunction

    // Adds one accepted pair to the sums; a full window frames four words.
    function automatic void accumulate_and_frame(
        input logic [dcap_pkg::SAMPLE_W-1:0] master,
        input logic [dcap_pkg::SAMPLE_W-1:0] slave
    );
        logic closes_buffer;
        master_acc = master_acc + dcap_pkg::SUM_W'(master);
        slave_acc  = slave_acc + dcap_pkg::SUM_W'(slave);
        fill_count++;
        if (fill_count >= HALF_WINDOW) begin
            closes_buffer = (slot_model >= dcap_pkg::SLOT_W'(PACKETS_PER_BUFFER - 1));
            push_word(header_model, dcap_pkg::POS_HEADER, closes_buffer);
            push_word(packet_count, dcap_pkg::POS_COUNTER, closes_buffer);
            push_word(dcap_pkg::WORD_W'(master_acc / HALF_WINDOW),
                      dcap_pkg::POS_MASTER, closes_buffer);
            push_word(dcap_pkg::WORD_W'(slave_acc / HALF_WINDOW),
                      dcap_pkg::POS_SLAVE, closes_buffer);
            master_acc   = '0;
            slave_acc    = '0;
            fill_count   = 0;
            packet_count = packet_count + 1;
            if (closes_buffer) begin
                slot_model = '0;
                half_model = ~half_model;
            end else begin
                slot_model = slot_model + 1'b1;
            end
        end
    endfunction

    // Receiver: check each accepted word against the oldest prediction,
    // then choose the ready level for the next cycle.
    always @(posedge i_clk) begin
        t_framed_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_words.size() == 0) begin
                record_failure($sformatf("unexpected word %h pos %0d",
                                         o_packet_word, o_word_position));
            end else begin
                want = expected_words.pop_front();
                if (o_packet_word !== want.word || o_word_position !== want.pos ||
                    o_packet_slot !== want.slot || o_buffer_half !== want.half ||
                    o_buffer_complete !== want.buf_done || o_last !== want.last) begin
                    record_failure($sformatf(
                        "word exp %h/%0d/%0d/%0b/%0b/%0b got %h/%0d/%0d/%0b/%0b/%0b",
                        want.word, want.pos, want.slot, want.half, want.buf_done,
                        want.last, o_packet_word, o_word_position, o_packet_slot,
                        o_buffer_half, o_buffer_complete, o_last));
                end
            end
        end
        rx_pattern <= {rx_pattern[0], rx_pattern[15:1]};
        if (rx_hold) begin
            i_ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:  i_ready <= 1'b1;
                RX_PATTERN: i_ready <= rx_pattern[0];
                default:    i_ready <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Offers one pair and waits for the transaction; valid stays high.
    task automatic send_pair(input logic [dcap_pkg::SAMPLE_W-1:0] master,
                             input logic [dcap_pkg::SAMPLE_W-1:0] slave);
        i_valid         <= 1'b1;
        i_master_sample <= master;
        i_slave_sample  <= slave;
        valid_high = 1'b1;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        accumulate_and_frame(master, slave);
    endtask

    // Lowers valid and waits on the clock before returning, so it is never raised in the same step.
    task automatic drop_valid();
        if (valid_high) begin
            i_valid <= 1'b0;
            valid_high = 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_for_results();
        drop_valid();
        while (expected_words.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Header writes happen only with the block drained and settled.
    task automatic write_header(input logic [dcap_pkg::WORD_W-1:0] value);
        wait_for_results();
        repeat (CFG_SETTLE) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        header_model = value;
    endtask

    function automatic t_window_flavor pick_flavor();
        case ($urandom_range(0, 7))
            0:       pick_flavor = FLAVOR_FULL_SCALE;
            1:       pick_flavor = FLAVOR_ZERO;
            2:       pick_flavor = FLAVOR_CORNERS;
            3:       pick_flavor = FLAVOR_SPLIT;
            default: pick_flavor = FLAVOR_UNIFORM;
        endcase
    endfunction

    function automatic logic [dcap_pkg::SAMPLE_W-1:0] draw_sample(
        input t_window_flavor flavor,
        input logic           is_master
    );
        case (flavor)
            FLAVOR_FULL_SCALE: draw_sample = '1;
            FLAVOR_ZERO:       draw_sample = '0;
            FLAVOR_SPLIT:      draw_sample = is_master ? '1 : '0;
            FLAVOR_CORNERS: begin
                case ($urandom_range(0, 4))
                    0:       draw_sample = 12'd0;
                    1:       draw_sample = 12'd1;
                    2:       draw_sample = 12'd2048;
                    3:       draw_sample = 12'd4094;
                    default: draw_sample = 12'd4095;
                endcase
            end
            default: draw_sample = dcap_pkg::SAMPLE_W'($urandom_range(0, 4095));
        endcase
    endfunction

    // Sends a run of pairs; each new window draws its own flavor of samples.
    // With bursty set, bursts of random length are separated by random gaps.
    task automatic send_stream(input int unsigned count, input logic bursty);
        int unsigned    burst_left;
        int unsigned    gap;
        t_window_flavor flavor;
        burst_left = 0;
        flavor = FLAVOR_UNIFORM;
        repeat (count) begin
            if (fill_count == 0) begin
                flavor = pick_flavor();
            end
            if (bursty && burst_left == 0) begin
                burst_left = $urandom_range(1, 20);
                gap = $urandom_range(0, 6);
                if (gap != 0) begin
                    drop_valid();
                    repeat (gap - 1) @(posedge i_clk);
                end
            end
            send_pair(draw_sample(flavor, 1'b1), draw_sample(flavor, 1'b0));
            if (burst_left != 0) begin
                burst_left--;
            end
        end
    endtask

    // Field extremes and walking bits under the reset header; the window is
    // then closed at full scale so the first packet shows the reset header.
    task automatic test_directed_extremes();
        logic [dcap_pkg::SAMPLE_W-1:0] bit_mask;
        send_pair('0, '0);
        send_pair('1, '1);
        send_pair('1, '0);
        send_pair('0, '1);
        send_pair(12'hAAA, 12'h555);
        send_pair(12'h555, 12'hAAA);
        send_pair(12'd1, 12'd4094);
        send_pair(12'd2048, 12'd2047);
        for (int b = 0; b < dcap_pkg::SAMPLE_W; b++) begin
            bit_mask = '0;
            bit_mask[b] = 1'b1;
            send_pair(bit_mask, ~bit_mask);
        end
        send_pair(12'd4094, 12'd1);
        send_pair(12'h800, 12'h7FF);
        while (fill_count != 0) begin
            send_pair('1, '1);
        end
    endtask

    // Header register at its extremes and at a random value.
    task automatic test_header_register();
        write_header('0);
        rx_mode <= RX_RANDOM;
        send_stream(2 * HALF_WINDOW, 1'b1);
        write_header('1);
        send_stream(HALF_WINDOW, 1'b1);
        write_header($urandom());
        send_stream(HALF_WINDOW, 1'b0);
    endtask

    // The receiver holds off long enough for the block to stall its input
    // while the sender keeps offering pairs.
    task automatic test_backpressure();
        wait_for_results();
        rx_mode <= RX_ALWAYS;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                rx_hold <= 1'b0;
            end
        join_none
        send_stream(3 * HALF_WINDOW, 1'b0);
        wait_for_results();
    endtask

    // Random windows under varying pacing.
    task automatic test_random_windows();
        int unsigned random_items;
        int unsigned chunk;
        logic        bursty;
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            chunk = $urandom_range(16, 3 * HALF_WINDOW);
            if (chunk > RANDOM_ITEMS - random_items) begin
                chunk = RANDOM_ITEMS - random_items;
            end
            case ($urandom_range(0, 3))
                0: begin
                    rx_mode <= RX_ALWAYS;
                    bursty = 1'b0;
                end
                1: begin
                    rx_mode <= RX_PATTERN;
                    bursty = 1'b1;
                end
                default: begin
                    rx_mode <= RX_RANDOM;
                    bursty = 1'b1;
                end
            endcase
            send_stream(chunk, bursty);
            random_items += chunk;
            case ($urandom_range(0, 5))
                0:       write_header($urandom());
                1:       wait_for_results();
                default: ;
            endcase
        end
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_wr_en     <= 1'b0;
        i_cfg_wr_data   <= '0;
        i_valid         <= 1'b0;
        i_master_sample <= '0;
        i_slave_sample  <= '0;
        reset_model();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_extremes();
        test_header_register();
        test_backpressure();
        test_random_windows();

        // Drain, then give stray words time to show up.
        wait_for_results();
        repeat (END_SETTLE) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("dual_channel_average_packetizer: match");
        end else begin
            $display("dual_channel_average_packetizer: mismatch");
        end
        $finish;
    end

endmodule
